[hw/rtl/kbsc_pkg.sv]
// ----------------------------------------------------------------------------
// kbsc_pkg
// Shared widths, mask tables and the round permutation builder for the
// keyed 16-bit bit swap cipher.
// ----------------------------------------------------------------------------
`default_nettype none

package kbsc_pkg;

    localparam int WORD_BITS  = 16;
    localparam int WORD_IDX_W = $clog2(WORD_BITS);
    localparam int PAIR_COUNT = 8;
    localparam int SEL_BITS   = $clog2(PAIR_COUNT);
    localparam int ROUNDS_MAX = 5;
    localparam int ROUNDS_DEF = 5;
    localparam int KEY_BITS   = SEL_BITS * ROUNDS_MAX;

    // APB register map: 32-bit registers on word addresses; key at word 0, rest reads 0
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;
    localparam int REG_IDX_W  = APB_ADDR_W - 2;
    localparam logic [REG_IDX_W-1:0] REG_KEY = '0;

    // Mode flag carried in tuser
    localparam logic MODE_ENC = 1'b0;
    localparam logic MODE_DEC = 1'b1;

    typedef logic [WORD_BITS-1:0]  t_word;
    typedef logic [KEY_BITS-1:0]   t_key;
    typedef logic [SEL_BITS-1:0]   t_sel;
    typedef t_word                 t_mask_tbl [PAIR_COUNT];
    typedef logic [WORD_IDX_W-1:0] t_perm [WORD_BITS];

    localparam t_mask_tbl MASK_FROM = '{
        16'd14081, 16'd32173, 16'd18493, 16'd41387,
        16'd55823, 16'd43411, 16'd48593, 16'd11423
    };
    localparam t_mask_tbl MASK_TO = '{
        16'd57859, 16'd49031, 16'd49199, 16'd20011,
        16'd51803, 16'd4973,  16'd57787, 16'd40093
    };

    // Build the source map of one round: out[j] = in[perm[j]].
    // Replay the swap list on bit labels, low pair first or high pair first.
    function automatic t_perm perm_of(input int sel, input logic rev);
        t_perm     p;
        int        fp [WORD_BITS];
        int        tp [WORD_BITS];
        int        nf;
        int        nt;
        int        n;
        int        i;
        logic [WORD_IDX_W-1:0] tmp;
        nf = 0;
        nt = 0;
        for (int b = 0; b < WORD_BITS; b++) begin
            fp[b] = 0;
            tp[b] = 0;
            p[b]  = WORD_IDX_W'(b);
        end
        for (int b = 0; b < WORD_BITS; b++) begin
            if (MASK_FROM[sel][b]) begin
                fp[nf] = b;
                nf++;
            end
            if (MASK_TO[sel][b]) begin
                tp[nt] = b;
                nt++;
            end
        end
        n = (nf < nt) ? nf : nt;
        for (int k = 0; k < WORD_BITS; k++) begin
            if (k < n) begin
                i = rev ? (n - 1 - k) : k;
                tmp       = p[fp[i]];
                p[fp[i]]  = p[tp[i]];
                p[tp[i]]  = tmp;
            end
        end
        return p;
    endfunction

endpackage

`default_nettype wire

[hw/rtl/kbsc_round.sv]
// ----------------------------------------------------------------------------
// kbsc_round
// One cipher round: eight fixed permutations per direction, picked by three
// key bits and the mode flag.
// ----------------------------------------------------------------------------
`default_nettype none

module kbsc_round (
    input  wire logic            i_mode,
    input  wire kbsc_pkg::t_sel  i_sel,
    input  wire kbsc_pkg::t_word i_word,
    output kbsc_pkg::t_word      o_word
);
    import kbsc_pkg::*;

    t_word cand [2*PAIR_COUNT];

    // Each candidate is pure wiring; the permutation is fixed at elaboration.
    for (genvar d = 0; d < 2; d++) begin : g_dir
        for (genvar s = 0; s < PAIR_COUNT; s++) begin : g_sel
            localparam t_perm P = perm_of(s, 1'(d));
            for (genvar j = 0; j < WORD_BITS; j++) begin : g_bit
                assign cand[d*PAIR_COUNT + s][j] = i_word[P[j]];
            end
        end
    end

    assign o_word = cand[{i_mode, i_sel}];

endmodule

`default_nettype wire

[hw/rtl/kbsc_regs.sv]
// ----------------------------------------------------------------------------
// kbsc_regs
// APB register file holding the 15-bit cipher key.
// ----------------------------------------------------------------------------
`default_nettype none

module kbsc_regs (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [kbsc_pkg::APB_ADDR_W-1:0] paddr,
    input  wire logic [kbsc_pkg::APB_DATA_W-1:0] pwdata,
    output logic      [kbsc_pkg::APB_DATA_W-1:0] prdata,
    output logic                                 pready,
    output kbsc_pkg::t_key                       o_key
);
    import kbsc_pkg::*;

    logic [REG_IDX_W-1:0] reg_idx;
    logic                 wr_en;
    t_key                 r_key;

    assign reg_idx = paddr[APB_ADDR_W-1:2];
    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite & pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key <= '0;
        end else if (wr_en && reg_idx == REG_KEY) begin
            r_key <= pwdata[KEY_BITS-1:0];
        end
    end

    always_comb begin
        case (reg_idx)
            REG_KEY: prdata = {{(APB_DATA_W-KEY_BITS){1'b0}}, r_key};
            default: prdata = '0;
        endcase
    end

    assign o_key = r_key;

endmodule

`default_nettype wire

[hw/rtl/keyed_bit_swap_cipher16.sv]
// ----------------------------------------------------------------------------
// keyed_bit_swap_cipher16
// Keyed 16-bit bit-permutation cipher, encrypt or decrypt per item.
// Pipeline: input reg, then all rounds, then result reg; an accepted item
// moves into the result register and leaves when taken; a stall holds both.
// One item per cycle while unstalled; all rounds sit in one combinational pass.
// Reset (synchronous, active low) clears both valid flags and the key to 0.
// ----------------------------------------------------------------------------
`default_nettype none

module keyed_bit_swap_cipher16 #(
    parameter int ROUNDS = kbsc_pkg::ROUNDS_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    // stream in
    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  wire logic [15:0]                     s_axis_tdata,  // [15:0] data_word
    input  wire logic [0:0]                      s_axis_tuser,  // [0] mode
    // stream out
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    output logic [15:0]                          m_axis_tdata,  // [15:0] result_word
    // APB configuration
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [kbsc_pkg::APB_ADDR_W-1:0] paddr,
    input  wire logic [kbsc_pkg::APB_DATA_W-1:0] pwdata,
    output logic      [kbsc_pkg::APB_DATA_W-1:0] prdata,
    output logic                                 pready
);
    import kbsc_pkg::*;

    // Input stage
    logic  r_in_valid;
    logic  r_in_mode;
    t_word r_in_word;

    // Result stage
    logic  r_out_valid;
    t_word r_out_word;
    t_word n_out_word;

    logic  out_free;
    logic  in_free;
    t_key  key;

    // Word after each round; stage 0 is the registered input.
    t_word w_stage [ROUNDS+1];

    // Key register and APB decode
    kbsc_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_key   (key)
    );

    // The result register frees when empty or when its item is taken this
    // cycle; the input register frees when empty or when it can hand off downstream.
    assign out_free      = !r_out_valid || m_axis_tready;
    assign in_free       = !r_in_valid || out_free;
    assign s_axis_tready = in_free;

    // Round chain. Encryption walks key slices upward, decryption walks them
    // downward and uses each round's reverse swap order, i.e. its inverse.
    assign w_stage[0] = r_in_word;

    for (genvar r = 0; r < ROUNDS; r++) begin : g_round
        t_sel sel;
        assign sel = (r_in_mode == MODE_DEC) ? key[SEL_BITS*(ROUNDS-1-r) +: SEL_BITS]
                                             : key[SEL_BITS*r +: SEL_BITS];
        kbsc_round u_round (
            .i_mode (r_in_mode),
            .i_sel  (sel),
            .i_word (w_stage[r]),
            .o_word (w_stage[r+1])
        );
    end

    assign n_out_word = w_stage[ROUNDS];

    // Valid flags: advance an item whenever the next stage is free.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_free) begin
                r_in_valid <= s_axis_tvalid;
            end
            if (out_free) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    // Payload: load on accept, hold while stalled.
    always_ff @(posedge i_clk) begin
        if (in_free && s_axis_tvalid) begin
            r_in_mode <= s_axis_tuser[0];
            r_in_word <= s_axis_tdata;
        end
        if (out_free && r_in_valid) begin
            r_out_word <= n_out_word;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_word;

endmodule

`default_nettype wire

[hw/rtl/kbsc_checker.sv]
// ----------------------------------------------------------------------------
// kbsc_checker
// Port-level checks for the cipher: reset, latency, stall hold and key
// readback.
// ----------------------------------------------------------------------------
`default_nettype none

module kbsc_checker (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_s_tvalid,
    input  wire logic                            i_s_tready,
    input  wire logic                            i_m_tvalid,
    input  wire logic                            i_m_tready,
    input  wire logic [15:0]                     i_m_tdata,
    input  wire logic                            i_psel,
    input  wire logic                            i_penable,
    input  wire logic                            i_pwrite,
    input  wire logic [kbsc_pkg::APB_ADDR_W-1:0] i_paddr,
    input  wire logic [kbsc_pkg::APB_DATA_W-1:0] i_pwdata,
    input  wire logic [kbsc_pkg::APB_DATA_W-1:0] i_prdata
);
    import kbsc_pkg::*;

    logic s_acc;
    logic key_wr;
    logic key_sel;

    assign s_acc   = i_s_tvalid && i_s_tready;
    assign key_sel = i_paddr[APB_ADDR_W-1:2] == REG_KEY;
    assign key_wr  = i_psel && i_penable && i_pwrite && key_sel;

    // Reset empties the result register.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_m_tvalid)
        else $error("result valid right after reset");

    // A fresh result comes from an accepted item that passed the input register.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_m_tvalid) |-> $past(s_acc, 2))
        else $error("result appeared without a matching input");

    // With the sink ready once the item sits in the input register, it shows up as a result.
    a_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_acc ##1 i_m_tready |=> i_m_tvalid)
        else $error("result missing after unstalled accept");

    // A stalled result holds.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && !i_m_tready |=> i_m_tvalid && $stable(i_m_tdata))
        else $error("stalled result changed");

    // The key reads back as written.
    a_key_rb: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        key_wr ##1 key_sel |->
            i_prdata == {{(APB_DATA_W-KEY_BITS){1'b0}}, $past(i_pwdata[KEY_BITS-1:0])})
        else $error("key readback mismatch");

endmodule

bind keyed_bit_swap_cipher16 kbsc_checker u_kbsc_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (s_axis_tvalid),
    .i_s_tready (s_axis_tready),
    .i_m_tvalid (m_axis_tvalid),
    .i_m_tready (m_axis_tready),
    .i_m_tdata  (m_axis_tdata),
    .i_psel     (psel),
    .i_penable  (penable),
    .i_pwrite   (pwrite),
    .i_paddr    (paddr),
    .i_pwdata   (pwdata),
    .i_prdata   (prdata)
);

`default_nettype wire
